/* sv/lsts_pkg.sv */
// Shared types and constants for the LRU shadow tag store.
package lsts_pkg;

  localparam int ADDR_W = 48;
  localparam int REQ_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ACCESS = 2'd0,
    REQ_PROBE  = 2'd1,
    REQ_ERASE  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_IDX,
    ST_CMP,
    ST_UPD
  } st_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic lookup;
    logic update;
    logic clr_we;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_busy;
    logic clr_last;
  } ctl_sts_t;

endpackage

/* sv/lru_shadow_tag_store_unit.sv */
// Top level of the LRU shadow tag store: controller plus datapath.
// A request (access, probe or erase) is taken when start is high and busy is
// low; one cycle-wide out_valid strobe with out_hit follows per request and
// cannot be held off; busy stays high through it. With LINE_SIZE and NUM_SETS
// both powers of two a request passes the index, compare and update states,
// the strobe coming in the update state: the set's whole row is read from a
// single row memory, compared, and written back for an access or a hitting
// erase. Otherwise the index state lasts while the set index is formed: the
// address is folded modulo LINE_SIZE * NUM_SETS eight bits per cycle, reduced
// in two steps and divided by LINE_SIZE with a reciprocal multiply. After
// reset the block stays busy while it clears the row memory one set per cycle.
module lru_shadow_tag_store_unit #(
  parameter int NUM_SETS  = 64,
  parameter int NUM_WAYS  = 8,
  parameter int LINE_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lsts_pkg::REQ_W-1:0]  in_req_type,
  input  logic [lsts_pkg::ADDR_W-1:0] in_line_address,
  output logic                        out_valid,
  output logic                        out_hit
);

  lsts_pkg::ctl_cmd_t cmd;
  lsts_pkg::ctl_sts_t sts;

  lsts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lsts_dpath #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .LINE_SIZE (LINE_SIZE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_line_address (in_line_address),
    .out_hit         (out_hit)
  );

endmodule

/* sv/lsts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* sv/lsts_idx.sv */
// Set index unit: (address / LINE_SIZE) mod NUM_SETS, taken from the address bits when both are powers of two.
module lsts_idx #(
  parameter int NUM_SETS  = 64,
  parameter int LINE_SIZE = 64
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [lsts_pkg::ADDR_W-1:0]                addr,
  output logic                                       busy,
  output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] set_idx
);

  localparam int SW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int LBW  = $clog2(LINE_SIZE);
  localparam bit POW2 = ((LINE_SIZE & (LINE_SIZE - 1)) == 0) &&
                        ((NUM_SETS & (NUM_SETS - 1)) == 0);
  // bytes covered by one pass through all the sets
  localparam longint unsigned SPAN = longint'(LINE_SIZE) * longint'(NUM_SETS);
  localparam int MW   = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int ACW  = MW + 6;
  localparam int SH   = MW + LBW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + longint'(LINE_SIZE) - 1) / longint'(LINE_SIZE);
  localparam int RCW  = MW + 2;
  localparam int GRP  = 8;
  localparam int GB   = $clog2(GRP);
  localparam int NGRP = lsts_pkg::ADDR_W / GRP;
  localparam int PIW  = $clog2(lsts_pkg::ADDR_W);
  localparam int CW   = 4;
  localparam int LAST = NGRP + 2;

  function automatic logic [lsts_pkg::ADDR_W*MW-1:0] pmod_table();
    logic [lsts_pkg::ADDR_W*MW-1:0] t;
    longint unsigned v;
    t = '0;
    v = 64'd1 % SPAN;
    for (int i = 0; i < lsts_pkg::ADDR_W; i++) begin
      t[i*MW +: MW] = MW'(v);
      v = (v << 1) % SPAN;
    end
    return t;
  endfunction

  // weight of address bit i is 2**i mod SPAN
  localparam logic [lsts_pkg::ADDR_W*MW-1:0] PMOD = pmod_table();

  logic                        busy_r, busy_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [lsts_pkg::ADDR_W-1:0] dvd_r;
  logic [ACW-1:0]              acc_r;
  logic [SW-1:0]               set_r;
  logic [MW-1:0]               wt_a [lsts_pkg::ADDR_W];
  logic [PIW-1:0]              bit_idx;
  logic [ACW-1:0]              part;
  logic [ACW-1:0]              red_hi;
  logic [ACW-1:0]              red_lo;
  logic [MW+RCW-1:0]           prod;

  for (genvar g = 0; g < lsts_pkg::ADDR_W; g++) begin : g_wt
    assign wt_a[g] = PMOD[g*MW +: MW];
  end

  // Address folded modulo SPAN eight bits a cycle, reduced below SPAN in two
  // steps, then the line number within the span by reciprocal multiply.
  always_comb begin
    bit_idx = '0;
    part    = '0;
    if (cnt_r < CW'(NGRP)) begin
      for (int j = 0; j < GRP; j++) begin
        bit_idx = {cnt_r[PIW-GB-1:0], GB'(j)};
        if (dvd_r[bit_idx]) begin
          part = part + ACW'(wt_a[bit_idx]);
        end
      end
    end
    red_hi = acc_r;
    for (int k = 5; k >= 3; k--) begin
      if (red_hi >= ACW'(SPAN << k)) begin
        red_hi = red_hi - ACW'(SPAN << k);
      end
    end
    red_lo = acc_r;
    for (int k = 2; k >= 0; k--) begin
      if (red_lo >= ACW'(SPAN << k)) begin
        red_lo = red_lo - ACW'(SPAN << k);
      end
    end
    prod = acc_r[MW-1:0] * RCW'(RECIP);
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = !POW2;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(LAST)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= addr;
      acc_r <= '0;
      if (POW2) begin
        set_r <= SW'((addr >> LBW) & lsts_pkg::ADDR_W'(NUM_SETS - 1));
      end else begin
        set_r <= '0;
      end
    end else if (busy_r) begin
      if (cnt_r < CW'(NGRP)) begin
        acc_r <= acc_r + part;
      end else if (cnt_r == CW'(NGRP)) begin
        acc_r <= red_hi;
      end else if (cnt_r == CW'(NGRP + 1)) begin
        acc_r <= red_lo;
      end else begin
        set_r <= SW'(prod >> SH);
      end
    end
  end

  assign busy    = busy_r;
  assign set_idx = set_r;

endmodule

/* sv/lsts_ctrl.sv */
// Controller: clearing pass, request sequencing and result strobe.
module lsts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output lsts_pkg::ctl_cmd_t  cmd,
  input  lsts_pkg::ctl_sts_t  sts
);

  lsts_pkg::st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsts_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      lsts_pkg::ST_CLR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = lsts_pkg::ST_IDLE;
        end
      end
      lsts_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = lsts_pkg::ST_IDX;
        end
      end
      lsts_pkg::ST_IDX: begin
        if (!sts.idx_busy) begin
          cmd.rd_en = 1'b1;
          state_nxt = lsts_pkg::ST_CMP;
        end
      end
      lsts_pkg::ST_CMP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lsts_pkg::ST_UPD;
      end
      lsts_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        out_valid  = 1'b1;
        state_nxt  = lsts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lsts_pkg::ST_CLR;
      end
    endcase
  end

endmodule

/* sv/lsts_dpath.sv */
// Datapath: set row memory, tag compare, victim choice and LRU rank update.
module lsts_dpath #(
  parameter int NUM_SETS  = 64,
  parameter int NUM_WAYS  = 8,
  parameter int LINE_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsts_pkg::ctl_cmd_t          cmd,
  output lsts_pkg::ctl_sts_t          sts,
  input  logic [lsts_pkg::REQ_W-1:0]  in_req_type,
  input  logic [lsts_pkg::ADDR_W-1:0] in_line_address,
  output logic                        out_hit
);

  localparam int AW    = lsts_pkg::ADDR_W;
  localparam int RW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ENT_W = 1 + RW + AW;
  localparam int ROW_W = NUM_WAYS * ENT_W;

  lsts_pkg::req_t     req_r;
  logic [AW-1:0]      addr_r;
  logic [SW-1:0]      set_idx;
  logic               idx_busy;
  logic [SW-1:0]      clr_cnt_r;

  logic [ROW_W-1:0]   rdata;
  logic [ROW_W-1:0]   wdata;
  logic               we;
  logic [SW-1:0]      waddr;

  logic [AW-1:0]      tag_a  [NUM_WAYS];
  logic [RW-1:0]      rank_a [NUM_WAYS];
  logic [NUM_WAYS-1:0] vld_a;

  logic [NUM_WAYS-1:0] hit_vec, vict_vec;
  logic [RW-1:0]       hit_rank;
  logic [NUM_WAYS-1:0] hit_vec_r, vict_vec_r;
  logic [RW-1:0]       hit_rank_r;
  logic                hit_r;

  logic [AW-1:0]       tag_n  [NUM_WAYS];
  logic [RW-1:0]       rank_n [NUM_WAYS];
  logic [NUM_WAYS-1:0] vld_n;

  lsts_idx #(
    .NUM_SETS  (NUM_SETS),
    .LINE_SIZE (LINE_SIZE)
  ) u_idx (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.load),
    .addr    (in_line_address),
    .busy    (idx_busy),
    .set_idx (set_idx)
  );

  lsts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (set_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= lsts_pkg::req_t'(in_req_type);
      addr_r <= in_line_address;
    end
    if (cmd.lookup) begin
      hit_vec_r  <= hit_vec;
      vict_vec_r <= vict_vec;
      hit_rank_r <= hit_rank;
      hit_r      <= |hit_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + SW'(1);
    end
  end

  assign sts.idx_busy = idx_busy;
  assign sts.clr_last = (clr_cnt_r == SW'(NUM_SETS - 1));

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_a[w]  = rdata[w*ENT_W +: AW];
      rank_a[w] = rdata[w*ENT_W + AW +: RW];
      vld_a[w]  = rdata[w*ENT_W + AW + RW];
    end
  end

  // Lookup. A full set holds ranks 0..NUM_WAYS-1, so the LRU way is the one
  // with the top rank; otherwise the lowest free way takes the fill.
  always_comb begin
    logic found;
    found    = 1'b0;
    hit_rank = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit_vec[w] = vld_a[w] && (tag_a[w] == addr_r);
      if (hit_vec[w]) begin
        hit_rank = hit_rank | rank_a[w];
      end
      vict_vec[w] = 1'b0;
      if (&vld_a) begin
        vict_vec[w] = (rank_a[w] == RW'(NUM_WAYS - 1));
      end else if (!vld_a[w] && !found) begin
        vict_vec[w] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  // Row rewrite; the read data register still holds the row of this request.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_n[w]  = tag_a[w];
      rank_n[w] = rank_a[w];
      vld_n[w]  = vld_a[w];
      case (req_r)
        lsts_pkg::REQ_ACCESS: begin
          if (hit_r) begin
            if (hit_vec_r[w]) begin
              rank_n[w] = '0;
            end else if (vld_a[w] && (rank_a[w] < hit_rank_r)) begin
              rank_n[w] = rank_a[w] + RW'(1);
            end
          end else if (vict_vec_r[w]) begin
            tag_n[w]  = addr_r;
            vld_n[w]  = 1'b1;
            rank_n[w] = '0;
          end else if (vld_a[w]) begin
            rank_n[w] = rank_a[w] + RW'(1);
          end
        end
        lsts_pkg::REQ_ERASE: begin
          if (hit_r) begin
            if (hit_vec_r[w]) begin
              vld_n[w]  = 1'b0;
              rank_n[w] = '0;
            end else if (vld_a[w] && (rank_a[w] > hit_rank_r)) begin
              rank_n[w] = rank_a[w] - RW'(1);
            end
          end
        end
        default: begin
          rank_n[w] = rank_a[w];
        end
      endcase
    end
  end

  always_comb begin
    wdata = '0;
    if (!cmd.clr_we) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        wdata[w*ENT_W +: ENT_W] = {vld_n[w], rank_n[w], tag_n[w]};
      end
    end
    we    = cmd.clr_we ||
            (cmd.update && ((req_r == lsts_pkg::REQ_ACCESS) ||
                            ((req_r == lsts_pkg::REQ_ERASE) && hit_r)));
    waddr = cmd.clr_we ? clr_cnt_r : set_idx;
  end

  assign out_hit = hit_r;

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> $onehot0(hit_vec_r))
    else $error("more than one way matched the request");

  a_victim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> $onehot(vict_vec_r))
    else $error("victim selection is not exactly one way");

  a_idx_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.update) |-> !idx_busy)
    else $error("set row used while the index is still being formed");

  a_lookup_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> cmd.lookup)
    else $error("row read not followed by lookup");

endmodule

/* tb/lru_shadow_tag_store_unit_tb.sv */
// Self-checking testbench for the LRU shadow tag store: directed table, then random requests.
module lru_shadow_tag_store_unit_tb;

  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 8;
  localparam int LINE_SIZE  = 64;
  localparam int TOTAL_WAYS = NUM_SETS * NUM_WAYS;
  localparam int RANK_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SET_STRIDE = NUM_SETS * LINE_SIZE;  // next address mapping to the same set
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 880;
  localparam int N_HOT_TAGS = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [lsts_pkg::REQ_W-1:0] REQ_RSVD = 2'd3;  // reserved code, behaves as a probe
  localparam logic [lsts_pkg::ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct {
    logic [lsts_pkg::REQ_W-1:0]  req;
    logic [lsts_pkg::ADDR_W-1:0] addr;
    bit                          typed;
    bit                          hit;
  } stim_row_t;

  typedef struct {
    logic [lsts_pkg::REQ_W-1:0]  req;
    logic [lsts_pkg::ADDR_W-1:0] addr;
    logic                        hit;
  } hit_expect_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [lsts_pkg::REQ_W-1:0]    in_req_type = '0;
  logic [lsts_pkg::ADDR_W-1:0]   in_line_address = '0;
  logic                          out_valid;
  logic                          out_hit;

  // shadow copy of the directory
  logic [lsts_pkg::ADDR_W-1:0] dir_tag   [TOTAL_WAYS];
  logic                        dir_valid [TOTAL_WAYS];
  logic [RANK_W-1:0]           dir_rank  [TOTAL_WAYS];

  hit_expect_t                 pending_hits[$];
  stim_row_t                   directed_rows [N_DIRECTED];
  logic [lsts_pkg::ADDR_W-1:0] hot_tags [N_HOT_TAGS];
  int                          hot_sets [4];
  int                          fail_count = 0;
  int                          cycle_count = 0;

  lru_shadow_tag_store_unit #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .LINE_SIZE(LINE_SIZE)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_line_address(in_line_address),
    .out_valid(out_valid),
    .out_hit(out_hit)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_shadow_tag_store_unit test failed");
      $finish;
    end
  end

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Works out the hit flag of one request and moves the shadow directory on.
  task automatic apply_request(input logic [lsts_pkg::REQ_W-1:0] req,
                               input logic [lsts_pkg::ADDR_W-1:0] addr,
                               output logic hit);
    logic [lsts_pkg::ADDR_W-1:0] line_no;
    logic [RANK_W-1:0] r;
    int base;
    int hw;
    int victim;
    line_no = addr / LINE_SIZE;
    base = int'(line_no % NUM_SETS) * NUM_WAYS;
    hw = -1;
    for (int w = 0; w < NUM_WAYS; w++)
      if (hw < 0 && dir_valid[base+w] && dir_tag[base+w] == addr) hw = w;
    hit = (hw >= 0);
    if (req == lsts_pkg::REQ_ACCESS) begin
      if (hw >= 0) begin
        r = dir_rank[base+hw];
        for (int w = 0; w < NUM_WAYS; w++)
          if (dir_valid[base+w] && dir_rank[base+w] < r) dir_rank[base+w]++;
        dir_rank[base+hw] = '0;
      end else begin
        victim = -1;
        for (int w = 0; w < NUM_WAYS; w++)
          if (victim < 0 && !dir_valid[base+w]) victim = w;
        if (victim < 0) begin
          // set full: drop the oldest entry
          victim = 0;
          for (int w = 1; w < NUM_WAYS; w++)
            if (dir_rank[base+w] > dir_rank[base+victim]) victim = w;
        end
        for (int w = 0; w < NUM_WAYS; w++)
          if (w != victim && dir_valid[base+w]) dir_rank[base+w]++;
        dir_tag[base+victim]   = addr;
        dir_valid[base+victim] = 1'b1;
        dir_rank[base+victim]  = '0;
      end
    end else if (req == lsts_pkg::REQ_ERASE && hw >= 0) begin
      r = dir_rank[base+hw];
      for (int w = 0; w < NUM_WAYS; w++)
        if (dir_valid[base+w] && dir_rank[base+w] > r) dir_rank[base+w]--;
      dir_valid[base+hw] = 1'b0;
      dir_rank[base+hw]  = '0;
    end
  endtask

  // Presents one request, idling on random cycles when may_idle is set, until it is taken.
  task automatic issue(input logic [lsts_pkg::REQ_W-1:0] req,
                       input logic [lsts_pkg::ADDR_W-1:0] addr,
                       input bit typed, input bit typed_hit, input bit may_idle);
    logic hit;
    bit   offer;
    bit   taken;
    taken = 1'b0;
    in_req_type <= req;
    in_line_address <= addr;
    while (!taken) begin
      offer = !(may_idle && $urandom_range(0, 99) < 26);
      start <= offer;
      @(posedge clk);
      taken = offer && !busy;
    end
    apply_request(req, addr, hit);
    pending_hits.push_back('{req, addr, typed ? typed_hit : hit});
  endtask

  always @(posedge clk) begin
    hit_expect_t e;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        log_failure($sformatf("unexpected result hit=%0b", out_hit));
      end else begin
        e = pending_hits.pop_front();
        if (out_hit !== e.hit)
          log_failure($sformatf("req=%0d addr=%h hit exp=%0b got=%0b",
                                e.req, e.addr, e.hit, out_hit));
      end
    end
  end

  initial begin
    logic [lsts_pkg::REQ_W-1:0]  req;
    logic [lsts_pkg::ADDR_W-1:0] addr;
    logic [lsts_pkg::ADDR_W-1:0] line_no;
    int roll;

    for (int i = 0; i < TOTAL_WAYS; i++) begin
      dir_tag[i]   = '0;
      dir_valid[i] = 1'b0;
      dir_rank[i]  = '0;
    end

    directed_rows = '{
      '{lsts_pkg::REQ_PROBE,  '0,                  1'b1, 1'b0},
      '{lsts_pkg::REQ_ACCESS, '0,                  1'b1, 1'b0},
      '{lsts_pkg::REQ_ACCESS, '0,                  1'b1, 1'b1},
      '{REQ_RSVD,             '0,                  1'b1, 1'b1},
      '{lsts_pkg::REQ_ACCESS, ADDR_ONES,           1'b1, 1'b0},
      '{lsts_pkg::REQ_PROBE,  ADDR_ONES,           1'b1, 1'b1},
      '{lsts_pkg::REQ_ACCESS, 48'd1,               1'b1, 1'b0},  // same line, other address
      '{lsts_pkg::REQ_PROBE,  48'd1,               1'b0, 1'b0},
      '{lsts_pkg::REQ_ERASE,  '0,                  1'b1, 1'b1},
      '{lsts_pkg::REQ_ERASE,  '0,                  1'b1, 1'b0},  // erase of an absent line
      '{lsts_pkg::REQ_PROBE,  '0,                  1'b1, 1'b0},
      '{lsts_pkg::REQ_ACCESS, '0,                  1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(1 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(2 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(3 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(4 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(5 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(6 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(7 * SET_STRIDE), 1'b0, 1'b0},  // set overflows here
      '{lsts_pkg::REQ_PROBE,  48'd1,               1'b0, 1'b0},
      '{lsts_pkg::REQ_PROBE,  '0,                  1'b0, 1'b0},
      '{lsts_pkg::REQ_ERASE,  48'(3 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(8 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_ACCESS, 48'(9 * SET_STRIDE), 1'b0, 1'b0},
      '{lsts_pkg::REQ_PROBE,  '0,                  1'b0, 1'b0}
    };

    // a few lines per set beyond the way count, so hits and evictions both occur
    hot_tags[0] = '0;
    hot_tags[1] = ADDR_ONES;
    for (int i = 2; i < N_HOT_TAGS; i++)
      hot_tags[i] = lsts_pkg::ADDR_W'({$urandom(), $urandom()});
    hot_sets = '{0, 1, NUM_SETS / 2, NUM_SETS - 1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      issue(directed_rows[i].req, directed_rows[i].addr,
            directed_rows[i].typed, directed_rows[i].hit, 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      req = lsts_pkg::REQ_ACCESS;
      else if (roll < 80) req = lsts_pkg::REQ_PROBE;
      else if (roll < 95) req = lsts_pkg::REQ_ERASE;
      else                req = REQ_RSVD;
      if ($urandom_range(0, 99) < 80) begin
        line_no = hot_tags[$urandom_range(0, N_HOT_TAGS-1)] * NUM_SETS
                  + hot_sets[$urandom_range(0, 3)];
        addr = line_no * LINE_SIZE;
        if ($urandom_range(0, 9) == 0) addr = addr + $urandom_range(0, LINE_SIZE-1);
      end else begin
        addr = lsts_pkg::ADDR_W'({$urandom(), $urandom()});
      end
      // back-to-back stretch with no idle cycles
      issue(req, addr, 1'b0, 1'b0, !(i >= 350 && i < 500));
    end
    start <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_hits.size() == 0) begin
      $display("lru_shadow_tag_store_unit test passed");
    end else begin
      $display("lru_shadow_tag_store_unit test failed");
    end
    $finish;
  end

endmodule
